// ===== sv/linear_probe_hash_table_macros.svh =====
// Assertion helpers used by lpht_dp.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LPHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lpht: implication check failed");

// Next-cycle implication, disabled while reset is low.
`define LPHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lpht: next-cycle check failed");

`endif

// ===== sv/lpht_pkg.sv =====
package lpht_pkg;

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned PROBE_W  = 11;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned MOD_CW   = $clog2(KEY_W + 1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  // Register index codes (word index taken from paddr).
  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STS_INSERTED  = 2'd0,
    STS_FOUND     = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_CHECK
  } ctrl_state_e;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic probe_init;
    logic rd;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic probe_end;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/lpht_mod.sv =====
module lpht_mod (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [lpht_pkg::KEY_W-1:0]         dividend_i,
  input  logic [lpht_pkg::SIZE_W-1:0]        divisor_i,
  output logic [lpht_pkg::SIZE_W-1:0]        rem_o,
  output logic                               done_o
);

  logic [lpht_pkg::KEY_W-1:0]  dvd_q, dvd_d;
  logic [lpht_pkg::SIZE_W-1:0] rem_q, rem_d;
  logic [lpht_pkg::MOD_CW-1:0] cnt_q, cnt_d;
  logic [lpht_pkg::SIZE_W:0]   trial;

  // Restoring remainder, one dividend bit per cycle, MSB first.
  always_comb begin
    trial = {rem_q, dvd_q[lpht_pkg::KEY_W-1]};
    dvd_d = dvd_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      cnt_d = lpht_pkg::MOD_CW'(lpht_pkg::KEY_W);
    end else if (cnt_q != '0) begin
      dvd_d = {dvd_q[lpht_pkg::KEY_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = lpht_pkg::SIZE_W'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[lpht_pkg::SIZE_W-1:0];
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign rem_o  = rem_q;
  assign done_o = (cnt_q == '0);

endmodule

// ===== sv/lpht_dp.sv =====
`include "linear_probe_hash_table_macros.svh"

module lpht_dp #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpht_pkg::cmd_t                cmd_i,
  output lpht_pkg::sts_t                sts_o,
  input  logic                          operation_i,
  input  logic [lpht_pkg::KEY_W-1:0]    key_i,
  input  logic [lpht_pkg::SIZE_W-1:0]   table_size_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [1:0]                    status_o,
  output logic [lpht_pkg::SLOT_W-1:0]   slot_o,
  output logic [lpht_pkg::PROBE_W-1:0]  probes_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IW = ((AW > lpht_pkg::SIZE_W) ? AW : lpht_pkg::SIZE_W) + 1;
  localparam logic [IW-1:0] DEPTH_IW  = IW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic [lpht_pkg::SIZE_W-1:0] DEPTH_SAT = lpht_pkg::SIZE_W'(TABLE_DEPTH);

  logic [lpht_pkg::KEY_W-1:0] mem_q [TABLE_DEPTH];
  logic [lpht_pkg::KEY_W-1:0] rdata_q;

  lpht_pkg::op_e                op_q;
  logic [lpht_pkg::KEY_W-1:0]   key_q;
  logic [lpht_pkg::SIZE_W-1:0]  size_q, eff_size;
  logic [AW-1:0]                idx_q, idx_d, clr_q;
  logic [lpht_pkg::SIZE_W-1:0]  skipped_q, skip_inc;
  logic [IW-1:0]                idx_inc;
  logic                         out_valid_q;
  lpht_pkg::status_e            status_q, res_status;
  logic [lpht_pkg::SLOT_W-1:0]  slot_q, res_slot;
  logic [lpht_pkg::PROBE_W-1:0] probes_q, res_probes;

  logic [lpht_pkg::SIZE_W-1:0]  rem;
  logic                         mod_done;
  logic                         is_search, empty, match, last_skip;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [lpht_pkg::KEY_W-1:0]   wr_data;

  // Clamp the programmed size into 1..TABLE_DEPTH.
  always_comb begin
    if (table_size_i == '0) begin
      eff_size = lpht_pkg::SIZE_W'(1);
    end else if (IW'(table_size_i) > DEPTH_IW) begin
      eff_size = DEPTH_SAT;
    end else begin
      eff_size = table_size_i;
    end
  end

  lpht_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .dividend_i (key_i),
    .divisor_i  (eff_size),
    .rem_o      (rem),
    .done_o     (mod_done)
  );

  // Next slot along the probe path, wrapping at the table size.
  always_comb begin
    idx_inc = IW'(idx_q) + IW'(1);
    if (idx_inc >= IW'(size_q)) begin
      idx_d = '0;
    end else begin
      idx_d = AW'(idx_inc);
    end
  end

  assign is_search = (op_q == lpht_pkg::OP_SEARCH);
  assign empty     = (rdata_q == '0);
  assign match     = (rdata_q == key_q);
  assign skip_inc  = skipped_q + lpht_pkg::SIZE_W'(1);
  assign last_skip = (skip_inc == size_q);

  always_comb begin
    res_status = lpht_pkg::STS_FULL;
    res_slot   = '0;
    res_probes = lpht_pkg::PROBE_W'(skip_inc);
    priority if (empty) begin
      res_status = is_search ? lpht_pkg::STS_NOT_FOUND : lpht_pkg::STS_INSERTED;
      res_slot   = is_search ? '0 : lpht_pkg::SLOT_W'(idx_q);
      res_probes = lpht_pkg::PROBE_W'(skipped_q);
    end else if (is_search && match) begin
      res_status = lpht_pkg::STS_FOUND;
      res_slot   = lpht_pkg::SLOT_W'(idx_q);
      res_probes = lpht_pkg::PROBE_W'(skipped_q);
    end else if (is_search) begin
      res_status = lpht_pkg::STS_NOT_FOUND;
    end else begin
      res_status = lpht_pkg::STS_FULL;
    end
  end

  // One write port shared by the clearing sweep and inserts.
  assign wr_en   = cmd_i.clr_step || (cmd_i.finish && !is_search && empty);
  assign wr_addr = cmd_i.clr_step ? clr_q : idx_q;
  assign wr_data = cmd_i.clr_step ? '0 : key_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= lpht_pkg::OP_INSERT;
      key_q       <= '0;
      size_q      <= lpht_pkg::SIZE_W'(1);
      idx_q       <= '0;
      skipped_q   <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.load) begin
        op_q   <= lpht_pkg::op_e'(operation_i);
        key_q  <= key_i;
        size_q <= eff_size;
      end
      if (cmd_i.probe_init) begin
        idx_q     <= AW'(rem);
        skipped_q <= '0;
      end else if (cmd_i.advance) begin
        idx_q     <= idx_d;
        skipped_q <= skip_inc;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= res_status;
      slot_q   <= res_slot;
      probes_q <= res_probes;
    end
  end

  assign sts_o.clr_last  = (clr_q == LAST_ADDR);
  assign sts_o.mod_done  = mod_done;
  assign sts_o.probe_end = empty || (is_search && match) || last_skip;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign probes_o    = probes_q;

  `LPHT_ASSERT_NXT(a_finish_loads_out, clk_i, rst_ni, cmd_i.finish, out_valid_q)
  `LPHT_ASSERT_NXT(a_idx_in_range, clk_i, rst_ni, cmd_i.advance,
                   IW'(idx_q) < IW'(size_q))
  `LPHT_ASSERT_IMP(a_init_after_mod, clk_i, rst_ni, cmd_i.probe_init, mod_done)

endmodule

// ===== sv/lpht_ctrl.sv =====
module lpht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lpht_pkg::sts_t sts_i,
  output lpht_pkg::cmd_t cmd_o
);

  lpht_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpht_pkg::S_CLEAR: begin
        if (sts_i.clr_last) state_d = lpht_pkg::S_IDLE;
      end
      lpht_pkg::S_IDLE: begin
        if (in_valid_i) state_d = lpht_pkg::S_MOD;
      end
      lpht_pkg::S_MOD: begin
        if (sts_i.mod_done) state_d = lpht_pkg::S_READ;
      end
      lpht_pkg::S_READ: begin
        state_d = lpht_pkg::S_CHECK;
      end
      lpht_pkg::S_CHECK: begin
        if (!sts_i.probe_end) begin
          state_d = lpht_pkg::S_READ;
        end else if (sts_i.out_free) begin
          state_d = lpht_pkg::S_IDLE;
        end
      end
      default: state_d = lpht_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lpht_pkg::S_CLEAR: cmd_o.clr_step = 1'b1;
      lpht_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      lpht_pkg::S_MOD:   cmd_o.probe_init = sts_i.mod_done;
      lpht_pkg::S_READ:  cmd_o.rd = 1'b1;
      lpht_pkg::S_CHECK: begin
        cmd_o.advance = !sts_i.probe_end;
        cmd_o.finish  = sts_i.probe_end && sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpht_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/linear_probe_hash_table.sv =====
// Linear-probing hash table of positive 31-bit keys; a stored zero marks an
// empty slot. Each request on the input channel (in_valid_i/in_ready_o with
// operation_i, key_i) inserts or searches one key. Each request yields one
// response on the output channel (out_valid_o/out_ready_i with status_o,
// slot_o, probes_o).
// The home slot is key modulo the effective table size, found by a bit-serial
// remainder unit; the probe loop then visits each slot with a synchronous
// memory read followed by a compare. A new request can be taken in the cycle
// after the response is loaded.
// table_size sits at APB address 0; write it only while no request is open.
// After reset a clearing pass writes every slot to empty; in_ready_o stays
// low until it ends, while APB accesses still work.
// A response waits in the output register while out_ready_i is low; the next
// request is accepted meanwhile, and its final probe holds until the output
// register frees up.
module linear_probe_hash_table #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB-style configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpht_pkg::PADDR_W-1:0]  paddr,
  input  logic [lpht_pkg::PDATA_W-1:0]  pwdata,
  output logic [lpht_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [lpht_pkg::KEY_W-1:0]    key_i,
  // response channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [lpht_pkg::SLOT_W-1:0]   slot_o,
  output logic [lpht_pkg::PROBE_W-1:0]  probes_o
);

  logic [lpht_pkg::SIZE_W-1:0] table_size_q, table_size_d;
  logic                        reg_sel;
  logic                        cfg_wr;
  lpht_pkg::cmd_t              cmd;
  lpht_pkg::sts_t              sts;

  // Word index of the access; only table_size exists, other words read zero
  // and drop writes.
  assign reg_sel = (paddr[lpht_pkg::PADDR_W-1] == lpht_pkg::REG_TABLE_SIZE);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? lpht_pkg::PDATA_W'(table_size_q) : '0;

  // Hold the raw value; clamping to 1..TABLE_DEPTH happens per request.
  assign table_size_d = cfg_wr ? pwdata[lpht_pkg::SIZE_W-1:0] : table_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= lpht_pkg::SIZE_RESET;
    end else begin
      table_size_q <= table_size_d;
    end
  end

  // Sequencer: clearing pass, request accept, remainder wait, probe loop.
  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Slot store, remainder unit, probe index and counters, response register.
  lpht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .operation_i  (operation_i),
    .key_i        (key_i),
    .table_size_i (table_size_q),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .probes_o     (probes_o)
  );

endmodule
